### hdl/mrfr_pkg.sv
`default_nettype none

package mrfr_pkg;

  // Largest frame (ADU) in bytes, CRC included.
  localparam int unsigned MAX_FRAME_BYTES = 256;

  // Fixed field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CrcW   = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Configuration register indexes.
  localparam logic CFG_OWN_ADDRESS  = 1'b0;
  localparam logic CFG_RECEIVE_MODE = 1'b1;

  // Receive modes.
  localparam logic MODE_REQUEST  = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_GOOD   = 3'd1,
    ST_BADCRC = 3'd2,
    ST_OTHER  = 3'd3,
    ST_LONG   = 3'd4,
    ST_ABORT  = 3'd5
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             frame_abort;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [ByteW-1:0]  byte_index;
    logic              frame_done;
    status_e           frame_status;
    logic [ByteW-1:0]  function_code;
    logic [CountW-1:0] frame_length;
  } out_item_t;

  // One byte into CRC-16/MODBUS, reflected, least significant bit first.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Bytes between the function code and the data, the last being the byte
  // count where the function has one.
  function automatic logic [3:0] meta_count(input logic [ByteW-1:0] fc, input logic mode);
    logic [3:0] m;
    if (mode == MODE_REQUEST) begin
      case (fc) inside
        [8'd0:8'd6]:   m = 4'd4;
        8'd15, 8'd16:  m = 4'd5;
        8'd22:         m = 4'd6;
        8'd23:         m = 4'd9;
        default:       m = 4'd0;
      endcase
    end else begin
      case (fc) inside
        8'd5, 8'd6, 8'd15, 8'd16: m = 4'd4;
        8'd22:                    m = 4'd6;
        default:                  m = 4'd1;
      endcase
    end
    return m;
  endfunction

  // Data bytes still due plus the two CRC bytes.
  function automatic logic [CountW-1:0] data_count(input logic [ByteW-1:0] fc,
                                                   input logic [ByteW-1:0] cnt,
                                                   input logic have_meta,
                                                   input logic mode);
    logic [ByteW-1:0] len;
    len = '0;
    if (have_meta) begin
      if (mode == MODE_REQUEST) begin
        case (fc) inside
          8'd15, 8'd16, 8'd23: len = cnt;
          default:             len = '0;
        endcase
      end else begin
        case (fc) inside
          [8'd0:8'd4], 8'd17, 8'd23: len = cnt;
          default:                   len = '0;
        endcase
      end
    end
    return {1'b0, len} + 9'd2;
  endfunction

endpackage

`default_nettype wire

### hdl/mrfr_stream_if.sv
`default_nettype none

interface mrfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/mrfr_in_reg.sv
`default_nettype none

module mrfr_in_reg
  import mrfr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mrfr_stream_if.sink   rx_i,
  mrfr_stream_if.source item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Take a new byte whenever the stage is empty or is being drained.
  assign rx_i.ready = !valid_q || item_o.ready;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= rx_i.payload;
    end
  end

  assign item_o.valid   = valid_q;
  assign item_o.payload = item_q;

endmodule

`default_nettype wire

### hdl/mrfr_frame_core.sv
`default_nettype none

module mrfr_frame_core
  import mrfr_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ByteW-1:0] own_address_i,
  input  wire logic             receive_mode_i,
  mrfr_stream_if.sink           item_i,
  mrfr_stream_if.source         res_o
);

  localparam logic [CountW:0] MaxLimit = (CountW+1)'(MaxFrameBytes);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_META   = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] rcv_q, rcv_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [CrcW-1:0]   ctail_q, ctail_d;
  logic [CrcW-1:0]   last_q, last_d;
  logic [ByteW-1:0]  addr_q, addr_d;
  logic [ByteW-1:0]  func_q, func_d;

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      take;

  assign item_i.ready = !out_valid_q || res_o.ready;
  assign take         = item_i.valid && item_i.ready;

  always_comb begin
    logic [ByteW-1:0]  b;
    logic [CountW-1:0] idx;
    logic [CountW-1:0] rem_dec;
    logic [3:0]        m;
    logic [CountW-1:0] d;
    logic [CountW:0]   total;
    logic [CrcW-1:0]   rx_crc;
    logic              to_data;
    logic              have_meta;
    logic              done;
    status_e           status;

    b         = item_i.payload.rx_byte;
    idx       = rcv_q;
    to_data   = 1'b0;
    have_meta = 1'b0;
    done      = 1'b0;
    status    = ST_BUSY;
    m         = '0;
    d         = '0;
    total     = '0;
    rx_crc    = '0;

    phase_d = phase_q;
    rcv_d   = rcv_q + 9'd1;
    addr_d  = (idx == 9'd0) ? b : addr_q;
    func_d  = (idx == 9'd1) ? b : func_q;
    crc_d   = crc_feed(crc_q, b);
    ctail_d = (idx >= 9'd2) ? crc_feed(ctail_q, last_q[15:8]) : ctail_q;
    last_d  = {last_q[7:0], b};
    rem_dec = (rem_q != '0) ? rem_q - 9'd1 : '0;
    rem_d   = rem_dec;

    if (rem_dec == '0) begin
      case (phase_q)
        PH_META: begin
          to_data   = 1'b1;
          have_meta = 1'b1;
        end
        PH_DATA: begin
          // CRC travels low byte first, so the newest byte is its high half.
          rx_crc = {last_d[7:0], last_d[15:8]};
          done   = 1'b1;
          if (addr_d != own_address_i && addr_d != '0) begin
            status = ST_OTHER;
          end else if (rx_crc == ctail_d) begin
            status = ST_GOOD;
          end else begin
            status = ST_BADCRC;
          end
        end
        default: begin
          m = meta_count(func_d, receive_mode_i);
          if (m != '0) begin
            phase_d = PH_META;
            rem_d   = {5'd0, m};
          end else begin
            to_data = 1'b1;
          end
        end
      endcase
      if (to_data) begin
        d     = data_count(func_d, b, have_meta, receive_mode_i);
        total = {1'b0, rcv_d} + {1'b0, d};
        if (total > MaxLimit) begin
          done   = 1'b1;
          status = ST_LONG;
        end else begin
          phase_d = PH_DATA;
          rem_d   = d;
        end
      end
    end

    out_d.data_byte     = b;
    out_d.byte_index    = idx[ByteW-1:0];
    out_d.frame_done    = done;
    out_d.frame_status  = status;
    out_d.function_code = func_d;
    out_d.frame_length  = done ? rcv_d : '0;

    if (item_i.payload.frame_abort) begin
      out_d.data_byte     = '0;
      out_d.byte_index    = rcv_q[ByteW-1:0];
      out_d.frame_done    = 1'b1;
      out_d.frame_status  = ST_ABORT;
      out_d.function_code = func_q;
      out_d.frame_length  = rcv_q;
      done                = 1'b1;
    end

    // A finished or discarded frame leaves the parser as after reset.
    if (done) begin
      phase_d = PH_HEADER;
      rcv_d   = '0;
      rem_d   = 9'd2;
      crc_d   = CrcInit;
      ctail_d = CrcInit;
      last_d  = '0;
      addr_d  = '0;
      func_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      rcv_q       <= '0;
      rem_q       <= 9'd2;
      crc_q       <= CrcInit;
      ctail_q     <= CrcInit;
      last_q      <= '0;
      addr_q      <= '0;
      func_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        rcv_q   <= rcv_d;
        rem_q   <= rem_d;
        crc_q   <= crc_d;
        ctail_q <= ctail_d;
        last_q  <= last_d;
        addr_q  <= addr_d;
        func_q  <= func_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

`default_nettype wire

### hdl/modbus_rtu_frame_receiver_unit.sv
// Modbus RTU frame receiver with CRC-16/MODBUS check.
// Bytes from the UART enter on rx_i (valid/ready); every accepted transfer
// yields exactly one result transfer on res_o, carrying the byte, its place
// in the frame, the function code and, on the last byte of a frame, the
// outcome: good, bad CRC, other address or too long. An item with
// frame_abort set stands for an inter-byte timeout: it discards the partial
// frame and reports status aborted with the count of discarded bytes.
// own_address and receive_mode are written via cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must do so only while no frame is in flight; the block does not enforce it.
// A byte taken on rx_i passes the input register and then the result
// register before it is shown on res_o.
// One byte is taken per cycle while res_o.ready stays high, since the CRC is
// updated a byte at a time by the logic between the input and result registers.
// The input register and the result register each hold one item, so a new
// byte is still taken while a finished result waits for the receiver; when
// both are full, rx_i.ready drops until res_o.ready returns.
// Reset empties both registers, returns the parser to the start of a frame
// and sets own_address to 1 and receive_mode to responses.
`default_nettype none

module modbus_rtu_frame_receiver_unit
  import mrfr_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [ByteW-1:0] cfg_data_i,
  mrfr_stream_if.sink           rx_i,
  mrfr_stream_if.source         res_o
);

  logic [ByteW-1:0] own_address_q;
  logic             receive_mode_q;

  // Configuration registers; a write lands on the edge its enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q  <= 8'd1;
      receive_mode_q <= MODE_RESPONSE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ADDRESS:  own_address_q  <= cfg_data_i;
        CFG_RECEIVE_MODE: receive_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Registered input byte between the UART side and the parser.
  mrfr_stream_if #(.T(in_item_t)) item_if ();

  mrfr_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .item_o (item_if)
  );

  // Frame parser and CRC check, writing the result register.
  mrfr_frame_core #(
    .MaxFrameBytes (MaxFrameBytes)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .own_address_i  (own_address_q),
    .receive_mode_i (receive_mode_q),
    .item_i         (item_if),
    .res_o          (res_o)
  );

endmodule

`default_nettype wire

### hdl/mrfr_checker.sv
`default_nettype none

module mrfr_checker
  import mrfr_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      res_valid_i,
  input wire logic      res_ready_i,
  input wire out_item_t res_payload_i
);

  // A result waiting for the receiver keeps its value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_payload_i))
    else $error("result changed while stalled");

  // Nothing is shown in the first cycle out of reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !res_valid_i)
    else $error("result shown straight after reset");

  // The status is in progress exactly when the frame is not finished.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |->
      ((res_payload_i.frame_status == ST_BUSY) == !res_payload_i.frame_done))
    else $error("status disagrees with frame_done");

  // A frame ended by a byte counts that byte; no length mid frame.
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_payload_i.frame_status != ST_ABORT |->
      (res_payload_i.frame_done ?
        (res_payload_i.frame_length == {1'b0, res_payload_i.byte_index} + 9'd1) :
        (res_payload_i.frame_length == '0)))
    else $error("frame_length does not match byte_index");

endmodule

bind modbus_rtu_frame_receiver_unit mrfr_checker u_mrfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

`default_nettype wire

### test/modbus_rtu_frame_receiver_unit_tb_pkg.sv
`timescale 1ns / 100ps

package mrfr_tb_pkg;
  import mrfr_pkg::*;

  // Modbus function codes that steer the frame length rules.
  localparam logic [7:0] FC_RESERVED      = 8'd0;
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
  localparam logic [7:0] FC_REPORT_ID     = 8'd17;
  localparam logic [7:0] FC_MASK_WRITE    = 8'd22;
  localparam logic [7:0] FC_READ_WRITE    = 8'd23;
  localparam logic [7:0] FC_EXCEPTION     = 8'h80;

  localparam logic [7:0] ADDR_BROADCAST = 8'h00;

  // Tracks the frame parser and keeps the reports still due from the block.
  class frame_tracker;
    typedef enum logic [1:0] {AT_HEADER, AT_META, AT_DATA} parse_e;

    logic [7:0]  own_addr;
    logic        rx_mode;
    parse_e      phase;
    int unsigned received;
    int unsigned remaining;
    logic [15:0] tail;
    logic [15:0] crc_lag;
    logic [7:0]  fr_addr;
    logic [7:0]  fr_func;
    out_item_t   due_reports[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned outcome_seen[6];

    function new();
      own_addr     = 8'd1;
      rx_mode      = MODE_RESPONSE;
      mismatches   = 0;
      results_seen = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      phase     = AT_HEADER;
      received  = 0;
      remaining = 2;
      tail      = '0;
      crc_lag   = CrcInit;
      fr_addr   = '0;
      fr_func   = '0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      end
      return x;
    endfunction

    static function int unsigned meta_len(logic [7:0] fc, logic mode);
      if (mode == MODE_REQUEST) begin
        if (fc <= FC_WRITE_REG) return 4;
        if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) return 5;
        if (fc == FC_MASK_WRITE) return 6;
        if (fc == FC_READ_WRITE) return 9;
        return 0;
      end
      if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG ||
          fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) return 4;
      if (fc == FC_MASK_WRITE) return 6;
      return 1;
    endfunction

    // Data bytes plus the two CRC bytes once the meta bytes are in.
    static function int unsigned tail_len(logic [7:0] fc, logic [7:0] cnt, bit counted,
                                          logic mode);
      bit uses;
      uses = 1'b0;
      if (counted) begin
        if (mode == MODE_REQUEST) begin
          uses = (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS || fc == FC_READ_WRITE);
        end else begin
          uses = (fc <= FC_READ_INPUT || fc == FC_REPORT_ID || fc == FC_READ_WRITE);
        end
      end
      return uses ? cnt + 2 : 2;
    endfunction

    function void note_byte(in_item_t it);
      out_item_t   r;
      int unsigned idx;
      int unsigned dlen;
      int unsigned m;
      logic [7:0]  b;
      bit          enter_data;
      bit          counted;
      bit          done;
      status_e     status;
      r = '0;
      b = it.rx_byte;
      if (it.frame_abort) begin
        r.byte_index    = received[7:0];
        r.frame_done    = 1'b1;
        r.frame_status  = ST_ABORT;
        r.function_code = fr_func;
        r.frame_length  = received[8:0];
        due_reports.push_back(r);
        restart();
        return;
      end
      enter_data = 1'b0;
      counted    = 1'b0;
      done       = 1'b0;
      status     = ST_BUSY;
      idx        = received;
      received   = received + 1;
      if (idx == 0) fr_addr = b;
      if (idx == 1) fr_func = b;
      if (idx >= 2) crc_lag = crc_step(crc_lag, tail[15:8]);
      tail = {tail[7:0], b};
      if (remaining > 0) remaining--;
      if (remaining == 0) begin
        case (phase)
          AT_META: begin
            enter_data = 1'b1;
            counted    = 1'b1;
          end
          AT_DATA: begin
            done = 1'b1;
            if (fr_addr != own_addr && fr_addr != ADDR_BROADCAST) status = ST_OTHER;
            else if ({tail[7:0], tail[15:8]} == crc_lag) status = ST_GOOD;
            else status = ST_BADCRC;
          end
          default: begin
            m = meta_len(fr_func, rx_mode);
            if (m != 0) begin
              phase     = AT_META;
              remaining = m;
            end else begin
              enter_data = 1'b1;
            end
          end
        endcase
        if (enter_data) begin
          dlen = tail_len(fr_func, b, counted, rx_mode);
          if (received + dlen > MAX_FRAME_BYTES) begin
            done   = 1'b1;
            status = ST_LONG;
          end else begin
            phase     = AT_DATA;
            remaining = dlen;
          end
        end
      end
      r.data_byte     = b;
      r.byte_index    = idx[7:0];
      r.frame_done    = done;
      r.frame_status  = status;
      r.function_code = fr_func;
      r.frame_length  = done ? received[8:0] : 9'd0;
      due_reports.push_back(r);
      if (done) restart();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: result %0d, %s expected %h, actual %h",
                 $time, results_seen, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_reports.size() == 0) begin
        $display("%0t: result %0d arrived with none due, actual %h", $time, results_seen, got);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("frame_done", want.frame_done, got.frame_done);
      compare_field("frame_status", want.frame_status, got.frame_status);
      compare_field("function_code", want.function_code, got.function_code);
      compare_field("frame_length", want.frame_length, got.frame_length);
      if (want.frame_done) outcome_seen[want.frame_status]++;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction
  endclass

endpackage

### test/modbus_rtu_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_unit_tb;
  import mrfr_pkg::*;
  import mrfr_tb_pkg::*;

  // A run that has not finished by now has hung somewhere.
  localparam int unsigned TimeoutNs = 10_000_000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [ByteW-1:0] cfg_data;
  bit               calm;
  int unsigned      items_sent;
  frame_tracker     tracker;

  mrfr_stream_if #(.T(in_item_t))  rx_if ();
  mrfr_stream_if #(.T(out_item_t)) res_if ();

  modbus_rtu_frame_receiver_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("modbus_rtu_frame_receiver_unit: mismatch");
    $finish;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one. In a calm stretch neither side idles at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return tracker.own_addr;
    if (r < 75) return ADDR_BROADCAST;
    return 8'($urandom);
  endfunction

  // Every code with a length rule of its own, exception responses, and the
  // odd unknown code that falls through to the default rules.
  function automatic logic [7:0] pick_function();
    case ($urandom_range(0, 15))
      0:       return FC_RESERVED;
      1:       return FC_READ_COILS;
      2:       return FC_READ_DISCRETE;
      3:       return FC_READ_HOLDING;
      4:       return FC_READ_INPUT;
      5:       return FC_WRITE_COIL;
      6:       return FC_WRITE_REG;
      7:       return FC_WRITE_COILS;
      8:       return FC_WRITE_REGS;
      9:       return FC_REPORT_ID;
      10:      return FC_MASK_WRITE;
      11:      return FC_READ_WRITE;
      12:      return FC_EXCEPTION | 8'($urandom_range(1, 23));
      default: return 8'($urandom);
    endcase
  endfunction

  // Byte counts are kept small so that frames stay short; a count of 255
  // overruns the largest frame for every function whose length uses the count.
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 96) return $urandom_range(13, 60);
    return 255;
  endfunction

  // The result side takes transfers with random stalls of its own.
  initial begin
    int unsigned hold;
    int unsigned g;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= 1'b0;
          hold = g - 1;
        end
      end
    end
  end

  // Every result transfer is checked against the oldest report still due.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      tracker.check_report(res_if.payload);
    end
  end

  // Offers one item and returns at the falling edge after its transfer, with
  // valid still high so that a back-to-back item needs no second assignment.
  task automatic send_item(input in_item_t it);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      rx_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.payload <= it;
    do @(posedge clk_i); while (!rx_if.ready);
    tracker.note_byte(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.rx_byte     = b;
    it.frame_abort = 1'b0;
    send_item(it);
  endtask

  // An inter-byte timeout; the byte that rides along must be ignored.
  task automatic send_abort();
    in_item_t it;
    it.rx_byte     = 8'($urandom);
    it.frame_abort = 1'b1;
    send_item(it);
  endtask

  // Builds a frame for the current receive mode: address, function, meta
  // bytes ending in the byte count, data and CRC. A frame that would run past
  // the largest ADU stops after its meta bytes, where the block ends it.
  // A non-zero cut below the frame length sends only that many bytes, then a timeout.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc,
                            input int unsigned count, input bit spoil,
                            input int unsigned cut);
    logic [7:0]  q[$];
    int unsigned m;
    int unsigned d;
    logic [15:0] c;
    m = frame_tracker::meta_len(fc, tracker.rx_mode);
    d = frame_tracker::tail_len(fc, count[7:0], m != 0, tracker.rx_mode) - 2;
    q.push_back(addr);
    q.push_back(fc);
    for (int i = 0; i < m; i++) q.push_back(i == m - 1 ? count[7:0] : 8'($urandom));
    if (q.size() + d + 2 <= MAX_FRAME_BYTES) begin
      for (int i = 0; i < d; i++) q.push_back(8'($urandom));
      c = CrcInit;
      foreach (q[i]) c = frame_tracker::crc_step(c, q[i]);
      if (spoil) c = c ^ (16'd1 << $urandom_range(0, 15));
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
    end
    if (cut != 0 && cut < q.size()) begin
      for (int i = 0; i < cut; i++) send_byte(q[i]);
      send_abort();
    end else begin
      foreach (q[i]) send_byte(q[i]);
    end
  endtask

  // Holds the sender off until every report due has come out. At least one
  // falling edge passes, so valid is never lowered and raised in one step.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
  endtask

  // Both registers are written on consecutive edges while the block is idle,
  // with the write enable held high across the pair.
  task automatic set_config(input logic [7:0] own, input logic mode);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_OWN_ADDRESS;
    cfg_data <= own;
    @(negedge clk_i);
    cfg_idx  <= CFG_RECEIVE_MODE;
    cfg_data <= {7'd0, mode};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tracker.own_addr = own;
    tracker.rx_mode  = mode;
  endtask

  // Mostly well-formed frames with random content; the rest is bad CRCs,
  // frames cut short by a timeout, stray bytes and lone aborts.
  task automatic random_phase(input int unsigned budget, input bit big);
    int unsigned first;
    int unsigned m;
    int unsigned r;
    logic [7:0]  fc;
    first = items_sent;
    if (big) begin
      // One frame of exactly the largest ADU, and one a byte too long.
      fc = (tracker.rx_mode == MODE_REQUEST) ? FC_WRITE_REGS : FC_READ_HOLDING;
      m  = frame_tracker::meta_len(fc, tracker.rx_mode);
      send_frame(tracker.own_addr, fc, MAX_FRAME_BYTES - 4 - m, 1'b0, 0);
      send_frame(tracker.own_addr, fc, MAX_FRAME_BYTES - 3 - m, 1'b0, 0);
    end
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 99) < 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 5) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        send_abort();
      end else if (r < 8) begin
        send_abort();
      end else begin
        send_frame(pick_address(), pick_function(), pick_count(),
                   $urandom_range(0, 9) == 0, r < 18 ? $urandom_range(1, 8) : 0);
      end
    end
    // Leave the parser at a frame boundary before the registers change.
    if (tracker.received != 0) send_abort();
  endtask

  initial begin
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_OWN_ADDRESS;
    cfg_data      = '0;
    rx_if.valid   = 1'b0;
    rx_if.payload = '0;
    calm          = 1'b0;
    items_sent    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first with the reset settings (own address 1, responses).
    // An abort with nothing pending still closes a frame of length zero.
    send_abort();
    // A good read response to the broadcast address.
    send_frame(ADDR_BROADCAST, FC_READ_HOLDING, 2, 1'b0, 0);
    // An exception response with a broken CRC.
    send_frame(8'd1, FC_EXCEPTION | FC_READ_HOLDING, 2, 1'b1, 0);
    // The same for another slave: the address check wins over the CRC.
    send_frame(8'hFF, FC_EXCEPTION | FC_READ_HOLDING, 2, 1'b1, 0);
    // A byte count that overruns the largest frame.
    send_frame(8'd1, FC_READ_HOLDING, 255, 1'b0, 0);
    // A request with no meta bytes goes straight to its two CRC bytes.
    set_config(8'hFF, MODE_REQUEST);
    send_frame(8'hFF, FC_REPORT_ID, 0, 1'b0, 0);

    // Random part over several register settings, the extremes among them.
    // The third setting runs with neither side idling.
    random_phase(90, 1'b1);
    set_config(8'h00, MODE_RESPONSE);
    random_phase(90, 1'b0);
    set_config(8'($urandom), MODE_REQUEST);
    calm = 1'b1;
    random_phase(90, 1'b0);
    calm = 1'b0;
    set_config(8'($urandom), MODE_RESPONSE);
    random_phase(90, 1'b0);
    set_config(8'd1, MODE_REQUEST);
    random_phase(90, 1'b0);
    set_config(8'hFF, MODE_RESPONSE);
    random_phase(90, 1'b0);

    // Let the last reports drain, then allow a few more cycles for anything
    // stray that the block might still emit.
    rx_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
    end
    $display("Run covered %0d input transfers and %0d result transfers, %0d field errors.",
             items_sent, tracker.results_seen, tracker.mismatches);
    $display("Frames closed: %0d good, %0d bad CRC, %0d other address, %0d too long, %0d aborted.",
             tracker.outcome_seen[ST_GOOD], tracker.outcome_seen[ST_BADCRC],
             tracker.outcome_seen[ST_OTHER], tracker.outcome_seen[ST_LONG],
             tracker.outcome_seen[ST_ABORT]);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("modbus_rtu_frame_receiver_unit: match");
    end else begin
      $display("modbus_rtu_frame_receiver_unit: mismatch");
    end
    $finish;
  end

endmodule

### modbus_rtu_frame_receiver_unit.f
hdl/mrfr_pkg.sv
hdl/mrfr_stream_if.sv
hdl/mrfr_in_reg.sv
hdl/mrfr_frame_core.sv
hdl/modbus_rtu_frame_receiver_unit.sv
hdl/mrfr_checker.sv
test/modbus_rtu_frame_receiver_unit_tb_pkg.sv
test/modbus_rtu_frame_receiver_unit_tb.sv
